// File: rtl/core/multilevel_feedback_thread_scheduler_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef MULTILEVEL_FEEDBACK_THREAD_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_THREAD_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define MLFQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define MLFQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`else

`define MLFQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MLFQ_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/mlfq_pkg.sv
// Shared constants, types and helper functions of the feedback queue scheduler.
`default_nettype none
package mlfq_pkg;

  localparam int LEVELS  = 3;
  localparam int THREADS = 16;

  localparam int TID_W   = 4;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W   = $clog2(THREADS);
  localparam int CNT_W   = $clog2(THREADS + 1);
  localparam int THR_AW  = $clog2(THREADS);
  localparam int SLOT_AW = $clog2(LEVELS * THREADS);

  typedef logic [TID_W-1:0]   tid_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [THR_AW-1:0]  thr_addr_t;
  typedef logic [SLOT_AW-1:0] slot_addr_t;

  localparam logic [2:0] ACT_CREATE = 3'd0;
  localparam logic [2:0] ACT_TICK   = 3'd1;
  localparam logic [2:0] ACT_YIELD  = 3'd2;
  localparam logic [2:0] ACT_EXIT   = 3'd3;
  localparam logic [2:0] ACT_BLOCK  = 3'd4;
  localparam logic [2:0] ACT_WAKE   = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic push;
    logic deq;
    logic load_run;
    logic strobe;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_dispatch;
  } sts_t;

  function automatic slot_addr_t slot_addr(input lvl_t lvl, input ptr_t ptr);
    slot_addr_t a;
    a = SLOT_AW'(lvl) * SLOT_AW'(THREADS) + SLOT_AW'(ptr);
    return a;
  endfunction

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t n;
    n = (p == PTR_W'(THREADS - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mlfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mlfq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/mlfq_ctrl.sv
// Controller state machine sequencing one scheduling event at a time.
`default_nettype none
module mlfq_ctrl
  import mlfq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire sts_t sts,
  output logic      busy,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PUSH   = 3'd1;
  localparam logic [2:0] S_DEQ    = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_LVLRD  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_PUSH;
      S_PUSH:  state_nxt = sts.need_dispatch ? S_DEQ : S_LVLRD;
      S_DEQ:   state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_LVLRD;
      S_LVLRD: state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign cmd.accept   = (state_r == S_IDLE) && start;
  assign cmd.push     = (state_r == S_PUSH);
  assign cmd.deq      = (state_r == S_DEQ);
  assign cmd.load_run = (state_r == S_LOAD);
  assign cmd.strobe   = (state_r == S_OUT);

endmodule
`default_nettype wire

// File: rtl/core/mlfq_dp.sv
// Datapath: level queues, per-thread levels and the running thread.
`default_nettype none
module mlfq_dp
  import mlfq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       cmd,
  input  wire logic [2:0] in_action,
  input  wire tid_t       in_thread_id,
  output sts_t            sts,
  output logic            running_valid,
  output tid_t            running_thread,
  output logic [1:0]      running_level,
  output logic            status
);

  logic [2:0] act_r, act_nxt;
  tid_t       tid_r, tid_nxt;
  ptr_t       heads_r [LEVELS];
  ptr_t       heads_nxt [LEVELS];
  ptr_t       tails_r [LEVELS];
  ptr_t       tails_nxt [LEVELS];
  cnt_t       counts_r [LEVELS];
  cnt_t       counts_nxt [LEVELS];
  tid_t       run_id_r, run_id_nxt;
  logic       run_flag_r, run_flag_nxt;
  logic       status_r, status_nxt;
  logic       hit_r, hit_nxt;

  // Queue slot RAM and thread level RAM ports.
  logic       rq_we;
  slot_addr_t rq_waddr, rq_raddr;
  tid_t       rq_wdata, rq_rdata;
  logic       lv_we;
  thr_addr_t  lv_waddr, lv_raddr;
  lvl_t       lv_wdata, lv_rdata;

  logic tid_ok;
  logic push_en;
  tid_t push_tid;
  lvl_t tgt;
  lvl_t lvl_clamped;
  logic deq_any;
  lvl_t deq_lvl;

  mlfq_ram #(.WIDTH(TID_W), .DEPTH(LEVELS * THREADS)) u_ready_ram (
    .clk   (clk),
    .we    (rq_we),
    .waddr (rq_waddr),
    .wdata (rq_wdata),
    .raddr (rq_raddr),
    .rdata (rq_rdata)
  );

  mlfq_ram #(.WIDTH(LVL_W), .DEPTH(THREADS)) u_level_ram (
    .clk   (clk),
    .we    (lv_we),
    .waddr (lv_waddr),
    .wdata (lv_wdata),
    .raddr (lv_raddr),
    .rdata (lv_rdata)
  );

  always_comb begin
    case (act_r) inside
      ACT_TICK, ACT_YIELD, ACT_EXIT, ACT_BLOCK: sts.need_dispatch = 1'b1;
      default:                                  sts.need_dispatch = 1'b0;
    endcase
  end

  assign tid_ok = (int'(tid_r) < THREADS);

  // The level read issued at accept is consumed in the push cycle; the read
  // of the running thread's level is consumed when the result is shown.
  assign lv_raddr = (cmd.accept && (in_action == ACT_WAKE)) ? THR_AW'(in_thread_id)
                                                            : THR_AW'(run_id_r);

  always_comb begin
    lvl_clamped = (int'(lv_rdata) >= LEVELS) ? LVL_W'(LEVELS - 1) : lv_rdata;
    tgt      = '0;
    push_en  = 1'b0;
    push_tid = run_id_r;
    case (act_r)
      ACT_CREATE: begin
        tgt      = '0;
        push_en  = tid_ok;
        push_tid = tid_r;
      end
      ACT_WAKE: begin
        tgt      = lvl_clamped;
        push_en  = tid_ok;
        push_tid = tid_r;
      end
      ACT_TICK: begin
        tgt     = (int'(lv_rdata) + 1 < LEVELS) ? lv_rdata + 1'b1 : LVL_W'(LEVELS - 1);
        push_en = run_flag_r;
      end
      ACT_YIELD: begin
        tgt     = lvl_clamped;
        push_en = run_flag_r;
      end
      default: begin
        tgt     = '0;
        push_en = 1'b0;
      end
    endcase
  end

  // Lowest-numbered non-empty level wins.
  always_comb begin
    deq_any = 1'b0;
    deq_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (counts_r[i] != '0) begin
        deq_any = 1'b1;
        deq_lvl = LVL_W'(i);
      end
    end
  end

  assign rq_raddr = slot_addr(deq_lvl, heads_r[deq_lvl]);
  assign rq_waddr = slot_addr(tgt, tails_r[tgt]);
  assign rq_wdata = push_tid;

  always_comb begin
    act_nxt      = act_r;
    tid_nxt      = tid_r;
    heads_nxt    = heads_r;
    tails_nxt    = tails_r;
    counts_nxt   = counts_r;
    run_id_nxt   = run_id_r;
    run_flag_nxt = run_flag_r;
    status_nxt   = status_r;
    hit_nxt      = hit_r;
    rq_we        = 1'b0;
    lv_we        = 1'b0;
    lv_waddr     = THR_AW'(tid_r);
    lv_wdata     = '0;

    if (cmd.accept) begin
      act_nxt    = in_action;
      tid_nxt    = in_thread_id;
      status_nxt = 1'b0;
    end

    if (cmd.push) begin
      if (push_en) begin
        if (counts_r[tgt] == CNT_W'(THREADS)) begin
          status_nxt = 1'b1;
        end else begin
          rq_we           = 1'b1;
          tails_nxt[tgt]  = ptr_inc(tails_r[tgt]);
          counts_nxt[tgt] = counts_r[tgt] + 1'b1;
        end
      end
      // The stored level changes even when the target queue is full.
      if ((act_r == ACT_CREATE) && tid_ok) begin
        lv_we    = 1'b1;
        lv_waddr = THR_AW'(tid_r);
        lv_wdata = '0;
      end else if ((act_r == ACT_TICK) && run_flag_r) begin
        lv_we    = 1'b1;
        lv_waddr = THR_AW'(run_id_r);
        lv_wdata = tgt;
      end
    end

    if (cmd.deq) begin
      hit_nxt = deq_any;
      if (deq_any) begin
        heads_nxt[deq_lvl]  = ptr_inc(heads_r[deq_lvl]);
        counts_nxt[deq_lvl] = counts_r[deq_lvl] - 1'b1;
        run_flag_nxt        = 1'b1;
      end else begin
        run_flag_nxt = 1'b0;
        run_id_nxt   = '0;
      end
    end

    if (cmd.load_run && hit_r) begin
      run_id_nxt = rq_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        heads_r[i]  <= '0;
        tails_r[i]  <= '0;
        counts_r[i] <= '0;
      end
      run_id_r   <= '0;
      run_flag_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      heads_r    <= heads_nxt;
      tails_r    <= tails_nxt;
      counts_r   <= counts_nxt;
      run_id_r   <= run_id_nxt;
      run_flag_r <= run_flag_nxt;
      hit_r      <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    tid_r    <= tid_nxt;
    status_r <= status_nxt;
  end

  assign running_valid  = run_flag_r;
  assign running_thread = run_flag_r ? run_id_r : '0;
  assign running_level  = run_flag_r ? 2'(lv_rdata) : 2'd0;
  assign status         = status_r;

endmodule
`default_nettype wire

// File: rtl/core/multilevel_feedback_thread_scheduler.sv
// Top level of the multilevel feedback queue thread scheduler.
//
// Usage: raise start with in_action and in_thread_id; the event is taken at
// the rising edge where start is high and busy is low. busy then stays high
// until the result beat has been shown.
// Each event yields exactly one result beat: out_valid is high for one cycle
// with out_running_valid, out_running_thread, out_running_level and
// out_status. The receiver cannot stall, so the beat must be taken then.
// From accept to the result beat, create, wake and unused action codes pass
// the push, level read and output states; tick, yield, exit and block add
// the dequeue and load states after the push. The next event can be taken
// in the cycle after the beat. The steps follow the registered reads of the
// level and queue slot RAMs: one read of the stored level, one queue push,
// one dequeue read and one read of the running thread's level for output.
// Synchronous reset (rst_n low) empties every level queue and leaves the
// block idle; the slot and level RAMs are not cleared and need no sweep.
`default_nettype none
`include "multilevel_feedback_thread_scheduler_macros.svh"
module multilevel_feedback_thread_scheduler
  import mlfq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_action,
  input  wire logic [3:0] in_thread_id,
  output logic            out_valid,
  output logic            out_running_valid,
  output logic [3:0]      out_running_thread,
  output logic [1:0]      out_running_level,
  output logic            out_status
);

  cmd_t cmd;
  sts_t sts;

  mlfq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  mlfq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_action      (in_action),
    .in_thread_id   (in_thread_id),
    .sts            (sts),
    .running_valid  (out_running_valid),
    .running_thread (out_running_thread),
    .running_level  (out_running_level),
    .status         (out_status)
  );

  assign out_valid = cmd.strobe;

  `MLFQ_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid)
  `MLFQ_ASSERT_NXT(a_single_beat, clk, rst_n, out_valid, !out_valid && !busy)
  `MLFQ_ASSERT_IMP(a_beat_busy, clk, rst_n, out_valid, busy)
  `MLFQ_ASSERT_IMP(a_idle_zero, clk, rst_n, !out_running_valid, ~|{out_running_thread, out_running_level})

endmodule
`default_nettype wire
